### rtl/wuq_pkg.sv
// Shared types, codes and constants of the wake-up event qualifier.
// Depends on nothing; every other file of the block imports it.
package wuq_pkg;

  // Converter resolution and the width of the sample field.
  localparam int ADC_BITS = 12;
  localparam int SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = (ADC_BITS >= SAMPLE_W) ?
      {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  // Samples averaged into the centre value. It must be a power of two, so that
  // the average is a plain shift.
  localparam int CENTER_SAMPLES = 8;
  localparam int AVG_SHIFT = $clog2(CENTER_SAMPLES);
  localparam int AVG_CNT_W = $clog2(CENTER_SAMPLES + 1);
  localparam int AVG_SUM_W = SAMPLE_W + AVG_SHIFT;

  localparam logic [7:0] UART_WAKE_BYTE = 8'hA5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [2:0] {
    KIND_ENTER_SLEEP = 3'd0,
    KIND_I2C_MATCH   = 3'd1,
    KIND_UART_BYTE   = 3'd2,
    KIND_PIN_EDGE    = 3'd3,
    KIND_PIN_SAMPLE  = 3'd4,
    KIND_PERIOD_EXP  = 3'd5,
    KIND_ADC_SAMPLE  = 3'd6,
    KIND_FILTER_TICK = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_WAKE   = 2'd1,
    ST_REJECT = 2'd2,
    ST_FAIL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SRC_I2C    = 2'd0,
    SRC_UART   = 2'd1,
    SRC_PIN    = 2'd2,
    SRC_PERIOD = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    MODE_DELTA   = 2'd0,
    MODE_RANGE   = 2'd1,
    MODE_DIGITAL = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MODE   = 3'd0,
    CFG_SET_POINT     = 3'd1,
    CFG_BAND_DELTA    = 3'd2,
    CFG_REJECT_INSIDE = 3'd3,
    CFG_PERIOD_LEVEL  = 3'd4,
    CFG_PIN_LEVEL     = 3'd5,
    CFG_PIN_READS     = 3'd6,
    CFG_WINDOW_TICKS  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    mode_e                period_mode;
    logic [SAMPLE_W-1:0]  set_point;
    logic [SAMPLE_W-1:0]  band_delta;
    logic                 reject_inside;
    logic                 period_level;
    logic                 pin_level;
    logic [7:0]           pin_reads;
    logic [7:0]           window_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [3:0]          criteria;
    logic [7:0]          rx_byte;
    logic                level;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;
  } item_t;

  typedef struct packed {
    status_e status;
    src_e    wake_source;
  } res_t;

endpackage

### rtl/wuq_if.sv
// Request channels of the wake-up event qualifier: events in, decisions out.
// Depends on wuq_pkg for the field types.
interface wuq_req_if;
  import wuq_pkg::*;

  logic                valid;
  logic                ready;
  kind_e               kind;
  logic [3:0]          criteria;
  logic [7:0]          rx_byte;
  logic                level;
  logic [SAMPLE_W-1:0] sample;
  logic                sample_ok;

  modport source (output valid, kind, criteria, rx_byte, level, sample, sample_ok,
                  input ready);
  modport sink (input valid, kind, criteria, rx_byte, level, sample, sample_ok,
                output ready);
endinterface

interface wuq_res_if;
  import wuq_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;
  src_e    wake_source;

  modport source (output valid, status, wake_source, input ready);
  modport sink (input valid, status, wake_source, output ready);
endinterface

### rtl/wuq_cfg_regs.sv
// Configuration register file of the wake-up event qualifier.
// Depends on wuq_pkg for the register indices and the cfg_t bundle.
module wuq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wuq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wuq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output wuq_pkg::cfg_t                 cfg_o
);
  import wuq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD_MODE:   cfg_d.period_mode   = mode_e'(cfg_data_i[1:0]);
        CFG_SET_POINT:     cfg_d.set_point     = cfg_data_i[SAMPLE_W-1:0];
        CFG_BAND_DELTA:    cfg_d.band_delta    = cfg_data_i[SAMPLE_W-1:0];
        CFG_REJECT_INSIDE: cfg_d.reject_inside = cfg_data_i[0];
        CFG_PERIOD_LEVEL:  cfg_d.period_level  = cfg_data_i[0];
        CFG_PIN_LEVEL:     cfg_d.pin_level     = cfg_data_i[0];
        CFG_PIN_READS:     cfg_d.pin_reads     = cfg_data_i[7:0];
        CFG_WINDOW_TICKS:  cfg_d.window_ticks  = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/wuq_decide.sv
// Sleep state machine and decision logic, with the registered result.
// Depends on wuq_pkg for codes, constants and the item, config and result types.
module wuq_decide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  wuq_pkg::item_t item_i,
  input  wuq_pkg::cfg_t  cfg_i,
  output wuq_pkg::res_t  res_o
);
  import wuq_pkg::*;

  typedef enum logic [2:0] {
    PH_AWAKE  = 3'd0,
    PH_CENTER = 3'd1,
    PH_ASLEEP = 3'd2,
    PH_PIN    = 3'd3,
    PH_WINDOW = 3'd4
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           enabled_q, enabled_d;
  logic [SAMPLE_W-1:0]  center_q, center_d;
  logic [AVG_SUM_W-1:0] sum_q, sum_d;
  logic [AVG_CNT_W-1:0] count_q, count_d;
  logic [7:0]           filter_q, filter_d;
  logic [SAMPLE_W-1:0]  band_lo_q, band_lo_d;
  logic [SAMPLE_W-1:0]  band_hi_q, band_hi_d;
  res_t                 res_q, res_d;

  logic [SAMPLE_W-1:0]  smp;
  logic [AVG_SUM_W-1:0] sum_inc;
  logic [AVG_CNT_W-1:0] count_inc;
  logic [SAMPLE_W-1:0]  centre;
  logic [SAMPLE_W:0]    band_top;
  logic [7:0]           filter_dec;
  logic                 in_band;

  assign smp       = item_i.sample & FULL_SCALE;
  assign sum_inc   = sum_q + AVG_SUM_W'(smp);
  assign count_inc = count_q + AVG_CNT_W'(1);
  assign filter_dec = filter_q - 8'd1;
  assign in_band   = (smp >= band_lo_q) && (smp <= band_hi_q);

  // Band centre for the window that a period expiry opens, clipped to full scale.
  always_comb begin
    centre = (cfg_i.period_mode == MODE_DELTA) ? center_q : cfg_i.set_point;
    if (centre > FULL_SCALE) begin
      centre = FULL_SCALE;
    end
    band_top = {1'b0, centre} + {1'b0, cfg_i.band_delta};
  end

  always_comb begin
    phase_d   = phase_q;
    enabled_d = enabled_q;
    center_d  = center_q;
    sum_d     = sum_q;
    count_d   = count_q;
    filter_d  = filter_q;
    band_lo_d = band_lo_q;
    band_hi_d = band_hi_q;
    res_d     = '{status: ST_NONE, wake_source: SRC_I2C};

    if (item_i.kind == KIND_ENTER_SLEEP) begin
      enabled_d = item_i.criteria;
      if (item_i.criteria == 4'd0) begin
        phase_d = PH_AWAKE;
      end else if (item_i.criteria[3] && cfg_i.period_mode == MODE_DELTA) begin
        sum_d   = '0;
        count_d = '0;
        phase_d = PH_CENTER;
      end else begin
        phase_d = PH_ASLEEP;
      end
    end else begin
      case (phase_q)
        PH_CENTER: begin
          if (item_i.kind == KIND_ADC_SAMPLE) begin
            if (!item_i.sample_ok) begin
              phase_d = PH_AWAKE;
              res_d   = '{status: ST_FAIL, wake_source: SRC_PERIOD};
            end else begin
              sum_d   = sum_inc;
              count_d = count_inc;
              if (count_inc >= AVG_CNT_W'(CENTER_SAMPLES)) begin
                center_d = sum_inc[AVG_SHIFT +: SAMPLE_W] & FULL_SCALE;
                phase_d  = PH_ASLEEP;
              end
            end
          end
        end
        PH_ASLEEP: begin
          if (item_i.kind == KIND_I2C_MATCH && enabled_q[0]) begin
            phase_d = PH_AWAKE;
            res_d   = '{status: ST_WAKE, wake_source: SRC_I2C};
          end else if (item_i.kind == KIND_UART_BYTE && enabled_q[1]) begin
            if (item_i.rx_byte == UART_WAKE_BYTE) begin
              phase_d = PH_AWAKE;
              res_d   = '{status: ST_WAKE, wake_source: SRC_UART};
            end else begin
              res_d   = '{status: ST_REJECT, wake_source: SRC_UART};
            end
          end else if (item_i.kind == KIND_PIN_EDGE && enabled_q[2]) begin
            if (cfg_i.pin_reads == 8'd0) begin
              phase_d = PH_AWAKE;
              res_d   = '{status: ST_WAKE, wake_source: SRC_PIN};
            end else begin
              filter_d = cfg_i.pin_reads;
              phase_d  = PH_PIN;
            end
          end else if (item_i.kind == KIND_PERIOD_EXP && enabled_q[3]) begin
            if (cfg_i.period_mode == MODE_INVALID) begin
              res_d = '{status: ST_REJECT, wake_source: SRC_PERIOD};
            end else begin
              band_lo_d = (centre >= cfg_i.band_delta) ? centre - cfg_i.band_delta : '0;
              band_hi_d = (band_top > {1'b0, FULL_SCALE}) ? FULL_SCALE :
                                                             band_top[SAMPLE_W-1:0];
              if (cfg_i.window_ticks == 8'd0) begin
                phase_d = PH_AWAKE;
                res_d   = '{status: ST_WAKE, wake_source: SRC_PERIOD};
              end else begin
                filter_d = cfg_i.window_ticks;
                phase_d  = PH_WINDOW;
              end
            end
          end
        end
        PH_PIN: begin
          if (item_i.kind == KIND_PIN_SAMPLE) begin
            if (item_i.level != cfg_i.pin_level) begin
              phase_d = PH_ASLEEP;
              res_d   = '{status: ST_REJECT, wake_source: SRC_PIN};
            end else begin
              filter_d = filter_dec;
              if (filter_dec == 8'd0) begin
                phase_d = PH_AWAKE;
                res_d   = '{status: ST_WAKE, wake_source: SRC_PIN};
              end
            end
          end
        end
        PH_WINDOW: begin
          if (item_i.kind == KIND_FILTER_TICK) begin
            filter_d = filter_dec;
            if (filter_dec == 8'd0) begin
              phase_d = PH_AWAKE;
              res_d   = '{status: ST_WAKE, wake_source: SRC_PERIOD};
            end
          end else if (item_i.kind == KIND_PIN_SAMPLE &&
                       cfg_i.period_mode == MODE_DIGITAL) begin
            if (item_i.level != cfg_i.period_level) begin
              phase_d = PH_ASLEEP;
              res_d   = '{status: ST_REJECT, wake_source: SRC_PERIOD};
            end
          end else if (item_i.kind == KIND_ADC_SAMPLE && cfg_i.period_mode == MODE_DELTA) begin
            // A failed conversion is ignored in delta mode.
            if (item_i.sample_ok && in_band) begin
              phase_d = PH_ASLEEP;
              res_d   = '{status: ST_REJECT, wake_source: SRC_PERIOD};
            end
          end else if (item_i.kind == KIND_ADC_SAMPLE && cfg_i.period_mode == MODE_RANGE) begin
            if (!item_i.sample_ok || (cfg_i.reject_inside ? in_band : !in_band)) begin
              phase_d = PH_ASLEEP;
              res_d   = '{status: ST_REJECT, wake_source: SRC_PERIOD};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_AWAKE;
      enabled_q <= '0;
      center_q  <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      filter_q  <= '0;
      band_lo_q <= '0;
      band_hi_q <= '0;
      res_q     <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      enabled_q <= enabled_d;
      center_q  <= center_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      filter_q  <= filter_d;
      band_lo_q <= band_lo_d;
      band_hi_q <= band_hi_d;
      res_q     <= res_d;
    end
  end

  assign res_o = res_q;

`ifndef SYNTH
  // Centring only runs when the period source was enabled.
  a_center_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CENTER |-> enabled_q[3])
    else $error("centring without the period source enabled");

  // The count never reaches the sample total while still centring.
  a_center_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CENTER |-> count_q < AVG_CNT_W'(CENTER_SAMPLES))
    else $error("centring sample count overran");

  // A running filter or window always has ticks left.
  a_filter_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIN || phase_q == PH_WINDOW) |-> filter_q != 8'd0)
    else $error("filter count exhausted without a decision");

  // Any sleeping phase has at least one source enabled.
  a_sleep_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ASLEEP || phase_q == PH_PIN || phase_q == PH_WINDOW) |->
    enabled_q != 4'd0)
    else $error("asleep with no wake source");

  // A wake or a centring failure always returns the block to awake.
  a_wake_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (res_d.status == ST_WAKE || res_d.status == ST_FAIL) |=>
    phase_q == PH_AWAKE)
    else $error("decision did not return the block to awake");
`endif

endmodule

### rtl/wakeup_event_qualifier.sv
// Wake-up event qualifier: takes one event request per cycle while its decisions
// are taken and returns one decision request for each, in order. Every request
// passes an input register and then the decision logic into the result register;
// the sustained rate is one request per clock, and the input register and the
// result register are the only limit. While a finished decision waits to
// be taken, the block accepts one further request into its input register and
// then stalls its input until the decision is taken. An enter_sleep request
// latches the enabled sources; with the period source enabled in analog delta
// mode, the next eight ADC samples are averaged into the band centre before
// sleep starts. While asleep, an I2C match, the UART wake byte 0xA5, a pin edge
// confirmed by a run of pin reads, or a period expiry followed by a clean check
// window end the sleep. Configuration is written through a plain write port and
// must only change while no request is in flight.
// Depends on wuq_pkg, wuq_if, wuq_cfg_regs and wuq_decide.
module wakeup_event_qualifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wuq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wuq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wuq_req_if.sink                        req_i,
  wuq_res_if.source                      res_o
);
  import wuq_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res;
  logic  in_valid_q;
  logic  out_valid_q;
  logic  advance;
  logic  req_take;

  // The held request moves on whenever the result register is free or being
  // emptied in this same cycle.
  assign advance   = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_take  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload needs no reset; it is only used while marked valid.
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      item_q <= '{kind:      req_i.kind,
                  criteria:  req_i.criteria,
                  rx_byte:   req_i.rx_byte,
                  level:     req_i.level,
                  sample:    req_i.sample,
                  sample_ok: req_i.sample_ok};
    end
  end

  wuq_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  wuq_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = res.status;
  assign res_o.wake_source = res.wake_source;

endmodule

### tb/sv/tb_wakeup_event_qualifier.sv
// Self-checking testbench for the wake-up event qualifier: directed tests, then long
// randomised sleep sequences under random idling on both request channels.
// Depends on wuq_pkg, wuq_if and the wakeup_event_qualifier RTL.
`timescale 1ns / 1ps

module tb_wakeup_event_qualifier;
  import wuq_pkg::*;

  // A run of this many cycles without any request moving on either side counts as a hang.
  localparam int WATCHDOG_CYCLES = 4000;
  // Length of the deliberate output stall that fills the block and blocks its input.
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1100;
  localparam int RANDOM_PHASES = 12;
  localparam int MAX_REPORTS = 10;
  localparam int FULL = int'(FULL_SCALE);

  // Sleep phases as the predictor tracks them.
  typedef enum logic [2:0] {
    PH_AWAKE,
    PH_CENTER,
    PH_ASLEEP,
    PH_PIN,
    PH_WINDOW
  } sleep_phase_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  wuq_req_if event_if ();
  wuq_res_if decision_if ();

  wakeup_event_qualifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (event_if.sink),
    .res_o      (decision_if.source)
  );

  // Predictor state: a private copy of the registers and of the sleep state.
  cfg_t                 pred_cfg;
  sleep_phase_e         pred_phase;
  logic [3:0]           pred_sources;
  logic [SAMPLE_W-1:0]  pred_centre;
  logic [SAMPLE_W-1:0]  pred_band_low;
  logic [SAMPLE_W-1:0]  pred_band_high;
  logic [AVG_SUM_W-1:0] pred_avg_sum;
  logic [AVG_CNT_W-1:0] pred_avg_cnt;
  logic [7:0]           pred_filter_cnt;

  // Decisions predicted for accepted event requests, oldest first.
  res_t pending_decisions[$];

  int   mismatches = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  int   pattern_left = 0;
  int   pattern_sel = 0;
  int   quiet_cycles = 0;
  int   events_sent = 0;

  item_t seen_event;
  res_t  wanted;
  bit    moved;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Ends a sleep decision: a wake returns to awake, a rejection goes back to sleep.
  function automatic res_t end_decision(bit wake, src_e src);
    res_t r;
    pred_phase    = wake ? PH_AWAKE : PH_ASLEEP;
    r.status      = wake ? ST_WAKE : ST_REJECT;
    r.wake_source = src;
    return r;
  endfunction

  // Works out the decision that one accepted event request must produce, and moves the
  // predicted sleep state on.
  function automatic res_t predict_decision(item_t ev);
    res_t                r;
    logic [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W:0]   top;
    logic                in_band;
    r.status      = ST_NONE;
    r.wake_source = SRC_I2C;
    smp           = ev.sample & FULL_SCALE;

    // Entering sleep restarts everything, whatever phase the block is in.
    if (ev.kind == KIND_ENTER_SLEEP) begin
      pred_sources = ev.criteria;
      if (ev.criteria == 4'd0) begin
        pred_phase = PH_AWAKE;
      end else if (ev.criteria[SRC_PERIOD] && pred_cfg.period_mode == MODE_DELTA) begin
        pred_avg_sum = '0;
        pred_avg_cnt = '0;
        pred_phase   = PH_CENTER;
      end else begin
        pred_phase = PH_ASLEEP;
      end
      return r;
    end

    case (pred_phase)
      PH_CENTER: begin
        if (ev.kind == KIND_ADC_SAMPLE) begin
          if (!ev.sample_ok) begin
            pred_phase    = PH_AWAKE;
            r.status      = ST_FAIL;
            r.wake_source = SRC_PERIOD;
            return r;
          end
          pred_avg_sum = pred_avg_sum + smp;
          pred_avg_cnt = pred_avg_cnt + 1'b1;
          if (pred_avg_cnt >= CENTER_SAMPLES) begin
            pred_centre = SAMPLE_W'(pred_avg_sum / CENTER_SAMPLES) & FULL_SCALE;
            pred_phase  = PH_ASLEEP;
          end
        end
      end

      PH_ASLEEP: begin
        if (ev.kind == KIND_I2C_MATCH && pred_sources[SRC_I2C]) begin
          return end_decision(1'b1, SRC_I2C);
        end
        if (ev.kind == KIND_UART_BYTE && pred_sources[SRC_UART]) begin
          return end_decision(ev.rx_byte == UART_WAKE_BYTE, SRC_UART);
        end
        if (ev.kind == KIND_PIN_EDGE && pred_sources[SRC_PIN]) begin
          if (pred_cfg.pin_reads == 8'd0) begin
            return end_decision(1'b1, SRC_PIN);
          end
          pred_filter_cnt = pred_cfg.pin_reads;
          pred_phase      = PH_PIN;
        end else if (ev.kind == KIND_PERIOD_EXP && pred_sources[SRC_PERIOD]) begin
          if (pred_cfg.period_mode == MODE_INVALID) begin
            return end_decision(1'b0, SRC_PERIOD);
          end
          // The band is fixed here, clipped at zero and at full scale.
          centre = (pred_cfg.period_mode == MODE_DELTA) ? pred_centre : pred_cfg.set_point;
          if (centre > FULL_SCALE) begin
            centre = FULL_SCALE;
          end
          pred_band_low = (centre >= pred_cfg.band_delta) ? centre - pred_cfg.band_delta : '0;
          top = {1'b0, centre} + pred_cfg.band_delta;
          pred_band_high = (top > FULL_SCALE) ? FULL_SCALE : top[SAMPLE_W-1:0];
          if (pred_cfg.window_ticks == 8'd0) begin
            return end_decision(1'b1, SRC_PERIOD);
          end
          pred_filter_cnt = pred_cfg.window_ticks;
          pred_phase      = PH_WINDOW;
        end
      end

      PH_PIN: begin
        if (ev.kind == KIND_PIN_SAMPLE) begin
          if (ev.level != pred_cfg.pin_level) begin
            return end_decision(1'b0, SRC_PIN);
          end
          pred_filter_cnt = pred_filter_cnt - 8'd1;
          if (pred_filter_cnt == 8'd0) begin
            return end_decision(1'b1, SRC_PIN);
          end
        end
      end

      PH_WINDOW: begin
        // The period mode is read live here, so a change during the window counts.
        if (ev.kind == KIND_FILTER_TICK) begin
          pred_filter_cnt = pred_filter_cnt - 8'd1;
          if (pred_filter_cnt == 8'd0) begin
            return end_decision(1'b1, SRC_PERIOD);
          end
        end else if (ev.kind == KIND_PIN_SAMPLE && pred_cfg.period_mode == MODE_DIGITAL) begin
          if (ev.level != pred_cfg.period_level) begin
            return end_decision(1'b0, SRC_PERIOD);
          end
        end else if (ev.kind == KIND_ADC_SAMPLE &&
                     (pred_cfg.period_mode == MODE_DELTA ||
                      pred_cfg.period_mode == MODE_RANGE)) begin
          in_band = (smp >= pred_band_low) && (smp <= pred_band_high);
          if (pred_cfg.period_mode == MODE_DELTA) begin
            // A failed conversion is simply ignored in delta mode.
            if (ev.sample_ok && in_band) begin
              return end_decision(1'b0, SRC_PERIOD);
            end
          end else begin
            if (!ev.sample_ok) begin
              return end_decision(1'b0, SRC_PERIOD);
            end
            if (pred_cfg.reject_inside ? in_band : !in_band) begin
              return end_decision(1'b0, SRC_PERIOD);
            end
          end
        end
      end

      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------
  // Monitor, scoreboard and watchdog
  // ---------------------------------------------------------------------------------

  // Both channels are looked at in one process, the event side first, so that a
  // decision is always predicted before it can be compared, whatever the latency.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (event_if.valid && event_if.ready) begin
        seen_event = '{kind: event_if.kind, criteria: event_if.criteria,
                       rx_byte: event_if.rx_byte, level: event_if.level,
                       sample: event_if.sample, sample_ok: event_if.sample_ok};
        pending_decisions.push_back(predict_decision(seen_event));
        moved = 1'b1;
      end
      if (decision_if.valid && decision_if.ready) begin
        moved = 1'b1;
        if (pending_decisions.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: decision request with none outstanding: status %0d source %0d",
                     $time, decision_if.status, decision_if.wake_source);
          end
        end else begin
          wanted = pending_decisions.pop_front();
          if (decision_if.status !== wanted.status ||
              decision_if.wake_source !== wanted.wake_source) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: decision mismatch: expected status %0d source %0d, got %0d %0d",
                       $time, wanted.status, wanted.wake_source,
                       decision_if.status, decision_if.wake_source);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Receiver: stalls on its own changing pattern, or holds off for a long stretch
  // ---------------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      decision_if.ready <= 1'b0;
      hold_left--;
    end else begin
      if (pattern_left == 0) begin
        pattern_sel  = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 80);
      end
      pattern_left--;
      case (pattern_sel)
        0:       decision_if.ready <= 1'b1;
        1:       decision_if.ready <= 1'($urandom_range(0, 1));
        2:       decision_if.ready <= (pattern_left % 3 != 0);
        default: decision_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------------

  // Offers one event request and returns at the clock edge at which it is taken. The
  // sender works in bursts; between bursts it may leave a random gap.
  task automatic send_event(input item_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        event_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    event_if.valid     <= 1'b1;
    event_if.kind      <= ev.kind;
    event_if.criteria  <= ev.criteria;
    event_if.rx_byte   <= ev.rx_byte;
    event_if.level     <= ev.level;
    event_if.sample    <= ev.sample;
    event_if.sample_ok <= ev.sample_ok;
    @(posedge clk_i);
    while (!event_if.ready) @(posedge clk_i);
    burst_left--;
    events_sent++;
  endtask

  // Stops offering and waits until every predicted decision has come back. The first
  // edge lets the scoreboard record the request taken at the current edge.
  task automatic wait_drained();
    event_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes one register once the block is idle, and mirrors it in the predictor.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PERIOD_MODE:   pred_cfg.period_mode   = mode_e'(data[1:0]);
      CFG_SET_POINT:     pred_cfg.set_point     = data[SAMPLE_W-1:0];
      CFG_BAND_DELTA:    pred_cfg.band_delta    = data[SAMPLE_W-1:0];
      CFG_REJECT_INSIDE: pred_cfg.reject_inside = data[0];
      CFG_PERIOD_LEVEL:  pred_cfg.period_level  = data[0];
      CFG_PIN_LEVEL:     pred_cfg.pin_level     = data[0];
      CFG_PIN_READS:     pred_cfg.pin_reads     = data[7:0];
      default:           pred_cfg.window_ticks  = data[7:0];
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(input cfg_t c);
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(c.period_mode));
    write_reg(CFG_SET_POINT, c.set_point);
    write_reg(CFG_BAND_DELTA, c.band_delta);
    write_reg(CFG_REJECT_INSIDE, CFG_DATA_W'(c.reject_inside));
    write_reg(CFG_PERIOD_LEVEL, CFG_DATA_W'(c.period_level));
    write_reg(CFG_PIN_LEVEL, CFG_DATA_W'(c.pin_level));
    write_reg(CFG_PIN_READS, CFG_DATA_W'(c.pin_reads));
    write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(c.window_ticks));
  endtask

  function automatic item_t make_event(kind_e k, logic [3:0] crit = '0,
                                       logic [7:0] rx = '0, logic lvl = 1'b0,
                                       logic [SAMPLE_W-1:0] smp = '0, logic ok = 1'b1);
    item_t ev;
    ev = '{kind: k, criteria: crit, rx_byte: rx, level: lvl, sample: smp, sample_ok: ok};
    return ev;
  endfunction

  // An event of the given kind with every other field random, so that fields the
  // block should not look at still toggle.
  function automatic item_t random_event(kind_e k);
    item_t ev;
    ev.kind      = k;
    ev.criteria  = 4'($urandom_range(0, 15));
    ev.rx_byte   = ($urandom_range(0, 3) == 0) ? UART_WAKE_BYTE : 8'($urandom_range(0, 255));
    ev.level     = 1'($urandom_range(0, 1));
    ev.sample    = SAMPLE_W'($urandom_range(0, FULL));
    ev.sample_ok = ($urandom_range(0, 9) != 0);
    return ev;
  endfunction

  // A sample value near the edges of the current band, or anywhere, clipped to the range.
  function automatic logic [SAMPLE_W-1:0] band_probe();
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'(pred_band_low);
      1:       v = int'(pred_band_high);
      2:       v = int'(pred_band_low) - 1;
      3:       v = int'(pred_band_high) + 1;
      4:       v = ($urandom_range(0, 1) == 0) ? 0 : FULL;
      default: v = $urandom_range(0, FULL);
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > FULL) begin
      v = FULL;
    end
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_level12();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return SAMPLE_W'($urandom_range(0, 400));
      default: return SAMPLE_W'($urandom_range(0, FULL));
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------------

  // With reset settings the block is awake: events do nothing, nor does an empty entry.
  task automatic test_awake_events();
    send_event(make_event(KIND_I2C_MATCH));
    send_event(make_event(KIND_ADC_SAMPLE, 4'd0, 8'd0, 1'b0, FULL_SCALE, 1'b0));
    send_event(make_event(KIND_ENTER_SLEEP, 4'd0));
  endtask

  // Sources that decide at once: I2C, the UART byte, a pin edge with no reads required
  // and a period expiry with an empty window. A disabled source is ignored.
  task automatic test_instant_wakes();
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(MODE_RANGE));
    send_event(make_event(KIND_ENTER_SLEEP, 4'hF));
    send_event(make_event(KIND_I2C_MATCH));
    send_event(make_event(KIND_ENTER_SLEEP, 4'h2));
    send_event(make_event(KIND_UART_BYTE, 4'd0, 8'hFF));
    send_event(make_event(KIND_UART_BYTE, 4'd0, UART_WAKE_BYTE));
    send_event(make_event(KIND_ENTER_SLEEP, 4'h4));
    send_event(make_event(KIND_I2C_MATCH));
    send_event(make_event(KIND_PIN_EDGE));
    send_event(make_event(KIND_ENTER_SLEEP, 4'h8));
    send_event(make_event(KIND_PERIOD_EXP));
  endtask

  // A pin edge needs a run of reads at the expected level; other events in between
  // are ignored and a read at the wrong level rejects.
  task automatic test_pin_filter();
    write_reg(CFG_PIN_READS, 12'd2);
    write_reg(CFG_PIN_LEVEL, 12'd1);
    send_event(make_event(KIND_ENTER_SLEEP, 4'h4));
    send_event(make_event(KIND_PIN_EDGE));
    send_event(make_event(KIND_PIN_SAMPLE, 4'd0, 8'd0, 1'b1));
    send_event(make_event(KIND_UART_BYTE, 4'd0, UART_WAKE_BYTE));
    send_event(make_event(KIND_PIN_SAMPLE, 4'd0, 8'd0, 1'b1));
    send_event(make_event(KIND_PIN_EDGE));
    send_event(make_event(KIND_ENTER_SLEEP, 4'h4));
    send_event(make_event(KIND_PIN_EDGE));
    send_event(make_event(KIND_PIN_SAMPLE, 4'd0, 8'd0, 1'b0));
  endtask

  // The period window in range mode with a band clipped at both ends, a failed
  // conversion, the invalid mode, and a mode change while the window is open.
  task automatic test_period_window();
    write_reg(CFG_WINDOW_TICKS, 12'd2);
    write_reg(CFG_SET_POINT, 12'hFFF);
    write_reg(CFG_BAND_DELTA, 12'hFFF);
    write_reg(CFG_REJECT_INSIDE, 12'd0);
    send_event(make_event(KIND_ENTER_SLEEP, 4'h8));
    send_event(make_event(KIND_PERIOD_EXP));
    send_event(make_event(KIND_ADC_SAMPLE, 4'd0, 8'd0, 1'b0, FULL_SCALE, 1'b1));
    send_event(make_event(KIND_ADC_SAMPLE, 4'd0, 8'd0, 1'b0, '0, 1'b0));
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(MODE_INVALID));
    send_event(make_event(KIND_PERIOD_EXP));
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(MODE_RANGE));
    send_event(make_event(KIND_PERIOD_EXP));
    // Now the window is open; in the invalid mode no sample can reject it.
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(MODE_INVALID));
    send_event(make_event(KIND_ADC_SAMPLE, 4'd0, 8'd0, 1'b0, '0, 1'b0));
    send_event(make_event(KIND_FILTER_TICK));
    send_event(make_event(KIND_FILTER_TICK));
  endtask

  // Delta mode measures a centre first; a failed conversion there aborts the sleep.
  task automatic test_centre_failure();
    write_reg(CFG_PERIOD_MODE, CFG_DATA_W'(MODE_DELTA));
    send_event(make_event(KIND_ENTER_SLEEP, 4'h8));
    send_event(make_event(KIND_ADC_SAMPLE, 4'd0, 8'd0, 1'b0, 12'h800, 1'b0));
  endtask

  // ---------------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------------

  // One sleep: entry, the centre measurement where delta mode needs it, then a few
  // well-formed wake-up sequences with random content and some noise among them.
  task automatic run_sleep_sequence();
    item_t ev;
    logic [3:0] crit;
    int base;
    int count;
    int miss_pct;
    crit = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                                         4'($urandom_range(1, 15));
    ev = random_event(KIND_ENTER_SLEEP);
    ev.criteria = crit;
    send_event(ev);

    if (crit[SRC_PERIOD] && pred_cfg.period_mode == MODE_DELTA) begin
      base = $urandom_range(0, FULL);
      for (int i = 0; i < CENTER_SAMPLES; i++) begin
        ev = random_event(KIND_ADC_SAMPLE);
        ev.sample_ok = ($urandom_range(0, 39) != 0);
        ev.sample = SAMPLE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, FULL) :
            (base + $urandom_range(0, 64) > FULL ? FULL : base + $urandom_range(0, 64)));
        send_event(ev);
        if (!ev.sample_ok) begin
          break;
        end
      end
    end

    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0: send_event(random_event(kind_e'($urandom_range(1, 7))));
        1, 2: send_event(random_event(KIND_I2C_MATCH));
        3, 4: send_event(random_event(KIND_UART_BYTE));
        5, 6: begin
          send_event(random_event(KIND_PIN_EDGE));
          miss_pct = (pred_cfg.pin_reads > 8'd16) ? 0 : 8;
          count = int'(pred_cfg.pin_reads) + $urandom_range(0, 1);
          for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_event(random_event(KIND_FILTER_TICK));
            end
            ev = random_event(KIND_PIN_SAMPLE);
            ev.level = ($urandom_range(0, 99) < miss_pct) ? !pred_cfg.pin_level :
                                                           pred_cfg.pin_level;
            send_event(ev);
          end
        end
        default: begin
          send_event(random_event(KIND_PERIOD_EXP));
          count = 0;
          while (count <= int'(pred_cfg.window_ticks)) begin
            case ((pred_cfg.window_ticks > 8'd16) ? 0 : $urandom_range(0, 3))
              0, 1: begin
                send_event(random_event(KIND_FILTER_TICK));
                count++;
              end
              2: begin
                ev = random_event(KIND_PIN_SAMPLE);
                ev.level = ($urandom_range(0, 6) == 0) ? !pred_cfg.period_level :
                                                         pred_cfg.period_level;
                send_event(ev);
              end
              default: begin
                ev = random_event(KIND_ADC_SAMPLE);
                ev.sample = band_probe();
                send_event(ev);
              end
            endcase
          end
        end
      endcase
    end
  endtask

  // Several register settings in turn, the extremes among them, each followed by a
  // share of the random sleep sequences.
  task automatic test_random_sleeps();
    cfg_t c;
    int target;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c.period_mode   = (ph < 8) ? mode_e'(ph % 4) : mode_e'($urandom_range(0, 2));
      c.set_point     = pick_level12();
      c.band_delta    = pick_level12();
      c.reject_inside = 1'($urandom_range(0, 1));
      c.period_level  = 1'($urandom_range(0, 1));
      c.pin_level     = 1'($urandom_range(0, 1));
      c.pin_reads     = (ph == 5) ? 8'd255 : 8'($urandom_range(0, 6));
      c.window_ticks  = (ph == 9) ? 8'd255 : 8'($urandom_range(0, 8));
      write_all_regs(c);
      target = events_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (events_sent < target) begin
        run_sleep_sequence();
      end
    end
  endtask

  // The receiver holds off for a long stretch while events keep coming, so the block
  // fills up and has to stall its input; afterwards everything must drain in order.
  task automatic test_output_stall();
    wait_drained();
    hold_left = HOLD_CYCLES;
    repeat (40) begin
      send_event(random_event(kind_e'($urandom_range(0, 7))));
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------------

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    event_if.valid     = 1'b0;
    event_if.kind      = KIND_ENTER_SLEEP;
    event_if.criteria  = '0;
    event_if.rx_byte   = '0;
    event_if.level     = 1'b0;
    event_if.sample    = '0;
    event_if.sample_ok = 1'b0;
    decision_if.ready  = 1'b0;

    pred_cfg        = '0;
    pred_phase      = PH_AWAKE;
    pred_sources    = '0;
    pred_centre     = '0;
    pred_band_low   = '0;
    pred_band_high  = '0;
    pred_avg_sum    = '0;
    pred_avg_cnt    = '0;
    pred_filter_cnt = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_awake_events();
    test_instant_wakes();
    test_pin_filter();
    test_period_window();
    test_centre_failure();
    test_output_stall();
    test_random_sleeps();

    // Let the last decisions come back; the watchdog bounds this wait.
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_decisions.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
